// ===== rtl/ofra_pkg.sv =====
// ----------------------------------------------------------------------------
// ofra_pkg
// Shared constants, codes, types and helpers for the ordered free-list room
// allocator.
// ----------------------------------------------------------------------------
package ofra_pkg;

   localparam int NUM_ROOMS  = 20;
   localparam int FIRST_ROOM = 101;

   localparam int IDX_W  = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
   localparam int CNT_W  = $clog2(NUM_ROOMS + 1);
   localparam int CALC_W = 10;
   localparam int OP_W   = 3;
   localparam int ST_W   = 3;
   localparam int ROOM_W = 8;
   localparam int OCC_W  = 16;
   localparam int SEL_W  = 3;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC_GIVEN = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE    = 3'd2;
   localparam logic [OP_W-1:0] OP_LIST_FREE  = 3'd3;
   localparam logic [OP_W-1:0] OP_LIST_USED  = 3'd4;

   // Result status codes.
   localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
   localparam logic [ST_W-1:0] ST_NO_FREE  = 3'd1;
   localparam logic [ST_W-1:0] ST_NOT_FREE = 3'd2;
   localparam logic [ST_W-1:0] ST_NOT_USED = 3'd3;
   localparam logic [ST_W-1:0] ST_ENTRY    = 3'd4;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;

   // Sources of the room and occupant fields of a result word.
   localparam logic [SEL_W-1:0] SEL_ZERO    = 3'd0;
   localparam logic [SEL_W-1:0] SEL_HEAD    = 3'd1;
   localparam logic [SEL_W-1:0] SEL_QPTR    = 3'd2;
   localparam logic [SEL_W-1:0] SEL_REQ_OCC = 3'd3;
   localparam logic [SEL_W-1:0] SEL_REQ     = 3'd4;
   localparam logic [SEL_W-1:0] SEL_USED    = 3'd5;

   typedef struct packed {
      logic             load_req;
      logic             ptr_clr;
      logic             ptr_inc;
      logic             take_head;
      logic             take_ptr;
      logic             release_room;
      logic             emit;
      logic [ST_W-1:0]  emit_status;
      logic [SEL_W-1:0] emit_sel;
      logic             emit_last;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            out_free;
      logic            count_zero;
      logic            used_zero;
      logic            given_ok;
      logic            release_ok;
      logic            ptr_end;
      logic            match;
      logic            ptr_last_free;
      logic            used_hit;
      logic            used_last;
   } sts_type;

   function automatic logic [ROOM_W-1:0] room_of(input logic [IDX_W-1:0] idx);
      logic [CALC_W-1:0] sum;
      sum = CALC_W'(FIRST_ROOM) + CALC_W'(idx);
      return sum[ROOM_W-1:0];
   endfunction

endpackage

// ===== rtl/ofra_ctrl.sv =====
// ----------------------------------------------------------------------------
// ofra_ctrl
// Room allocator sequencer: decodes the held request and steps the datapath
// through searches and list scans, one queue position per cycle unless stalled.
// ----------------------------------------------------------------------------
module ofra_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ofra_pkg::sts_type sts,
   output ofra_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DISPATCH  = 3'd1;
   localparam logic [2:0] S_SEARCH    = 3'd2;
   localparam logic [2:0] S_LIST_FREE = 3'd3;
   localparam logic [2:0] S_LIST_USED = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.op)
               ofra_pkg::OP_ALLOC: begin
                  if (sts.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     if (sts.count_zero) begin
                        cmd.emit_status = ofra_pkg::ST_NO_FREE;
                        cmd.emit_sel    = ofra_pkg::SEL_ZERO;
                     end else begin
                        cmd.take_head   = 1'b1;
                        cmd.emit_status = ofra_pkg::ST_DONE;
                        cmd.emit_sel    = ofra_pkg::SEL_HEAD;
                     end
                     state_in = S_IDLE;
                  end
               end
               ofra_pkg::OP_ALLOC_GIVEN: begin
                  if (sts.given_ok) begin
                     cmd.ptr_clr = 1'b1;
                     state_in    = S_SEARCH;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = ofra_pkg::ST_NOT_FREE;
                     cmd.emit_sel    = ofra_pkg::SEL_ZERO;
                     state_in        = S_IDLE;
                  end
               end
               ofra_pkg::OP_RELEASE: begin
                  if (sts.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     if (sts.release_ok) begin
                        cmd.release_room = 1'b1;
                        cmd.emit_status  = ofra_pkg::ST_DONE;
                        cmd.emit_sel     = ofra_pkg::SEL_REQ;
                     end else begin
                        cmd.emit_status = ofra_pkg::ST_NOT_USED;
                        cmd.emit_sel    = ofra_pkg::SEL_ZERO;
                     end
                     state_in = S_IDLE;
                  end
               end
               ofra_pkg::OP_LIST_FREE: begin
                  if (!sts.count_zero) begin
                     cmd.ptr_clr = 1'b1;
                     state_in    = S_LIST_FREE;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = ofra_pkg::ST_EMPTY;
                     cmd.emit_sel    = ofra_pkg::SEL_ZERO;
                     state_in        = S_IDLE;
                  end
               end
               ofra_pkg::OP_LIST_USED: begin
                  if (!sts.used_zero) begin
                     cmd.ptr_clr = 1'b1;
                     state_in    = S_LIST_USED;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = ofra_pkg::ST_EMPTY;
                     cmd.emit_sel    = ofra_pkg::SEL_ZERO;
                     state_in        = S_IDLE;
                  end
               end
               default: begin
                  // Unknown operations produce no word.
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SEARCH: begin
            if (sts.ptr_end) begin
               if (sts.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = ofra_pkg::ST_NOT_FREE;
                  cmd.emit_sel    = ofra_pkg::SEL_ZERO;
                  state_in        = S_IDLE;
               end
            end else if (sts.match) begin
               if (sts.out_free) begin
                  cmd.take_ptr    = 1'b1;
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = ofra_pkg::ST_DONE;
                  cmd.emit_sel    = ofra_pkg::SEL_REQ_OCC;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_LIST_FREE: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = sts.ptr_last_free;
               cmd.emit_status = ofra_pkg::ST_ENTRY;
               cmd.emit_sel    = ofra_pkg::SEL_QPTR;
               if (sts.ptr_last_free) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.ptr_inc = 1'b1;
               end
            end
         end
         S_LIST_USED: begin
            if (!sts.used_hit) begin
               cmd.ptr_inc = 1'b1;
            end else if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = sts.used_last;
               cmd.emit_status = ofra_pkg::ST_ENTRY;
               cmd.emit_sel    = ofra_pkg::SEL_USED;
               if (sts.used_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.ptr_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/ofra_dp.sv =====
// ----------------------------------------------------------------------------
// ofra_dp
// Datapath of the room allocator: free queue, in-use marks, occupant table,
// scan pointer and the result output register.
// ----------------------------------------------------------------------------
module ofra_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ofra_pkg::cmd_type             cmd,
   output ofra_pkg::sts_type             sts,
   input  logic [ofra_pkg::OP_W-1:0]     req_operation,
   input  logic [ofra_pkg::ROOM_W-1:0]   req_room_number,
   input  logic [ofra_pkg::OCC_W-1:0]    req_occupant,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ofra_pkg::ST_W-1:0]     rsp_status,
   output logic [ofra_pkg::ROOM_W-1:0]   rsp_room_out,
   output logic [ofra_pkg::OCC_W-1:0]    rsp_occupant_out,
   output logic                          rsp_last
);

   localparam int N     = ofra_pkg::NUM_ROOMS;
   localparam int IDX_W = ofra_pkg::IDX_W;
   localparam int CNT_W = ofra_pkg::CNT_W;
   localparam int CALC_W = ofra_pkg::CALC_W;

   // Held request.
   logic [ofra_pkg::OP_W-1:0]   op_ff;
   logic [ofra_pkg::ROOM_W-1:0] num_ff;
   logic [ofra_pkg::OCC_W-1:0]  occ_ff;

   // Allocator state.
   logic [IDX_W-1:0]            fo_ff [N];
   logic [IDX_W-1:0]            fo_in [N];
   logic [CNT_W-1:0]            count_ff;
   logic [N-1:0]                used_ff;
   logic [ofra_pkg::OCC_W-1:0]  occ_tbl_ff [N];
   logic [CNT_W-1:0]            ptr_ff;

   // Result register.
   logic                        rsp_valid_ff;
   logic [ofra_pkg::ST_W-1:0]   rsp_status_ff;
   logic [ofra_pkg::ROOM_W-1:0] rsp_room_ff;
   logic [ofra_pkg::OCC_W-1:0]  rsp_occ_ff;
   logic                        rsp_last_ff;

   logic [CALC_W-1:0]           num_wide;
   logic [CALC_W-1:0]           num_off;
   logic                        in_pool;
   logic [IDX_W-1:0]            req_idx;
   logic [IDX_W-1:0]            ptr_idx;
   logic [IDX_W-1:0]            qptr_val;
   logic                        take;
   logic [IDX_W-1:0]            take_idx;
   logic [CNT_W-1:0]            drop_pos;
   logic                        used_above;
   logic [ofra_pkg::ROOM_W-1:0] room_sel;
   logic [ofra_pkg::OCC_W-1:0]  occ_sel;

   assign num_wide = CALC_W'(num_ff);
   assign num_off  = num_wide - CALC_W'(ofra_pkg::FIRST_ROOM);
   assign in_pool  = (num_wide >= CALC_W'(ofra_pkg::FIRST_ROOM)) &&
                     (num_wide < CALC_W'(ofra_pkg::FIRST_ROOM + N));
   assign req_idx  = num_off[IDX_W-1:0];
   assign ptr_idx  = ptr_ff[IDX_W-1:0];
   assign qptr_val = fo_ff[ptr_idx];

   assign take     = cmd.take_head | cmd.take_ptr;
   assign take_idx = cmd.take_head ? fo_ff[0] : req_idx;
   assign drop_pos = cmd.take_head ? '0 : ptr_ff;

   // Any in-use room above the scan pointer means this is not the final word.
   always_comb begin
      used_above = 1'b0;
      for (int j = 0; j < N; j++) begin
         if (used_ff[j] && (CNT_W'(j) > ptr_ff)) begin
            used_above = 1'b1;
         end
      end
   end

   // The queue closes the gap of a removed entry in one step.
   always_comb begin
      fo_in = fo_ff;
      for (int i = 0; i < N - 1; i++) begin
         if (take && (CNT_W'(i) >= drop_pos) && (CNT_W'(i + 1) < count_ff)) begin
            fo_in[i] = fo_ff[i + 1];
         end
      end
      if (cmd.release_room) begin
         fo_in[count_ff[IDX_W-1:0]] = req_idx;
      end
   end

   always_comb begin
      sts               = '0;
      sts.op            = op_ff;
      sts.out_free      = !rsp_valid_ff || rsp_ready;
      sts.count_zero    = (count_ff == '0);
      sts.used_zero     = (used_ff == '0);
      sts.given_ok      = in_pool && !used_ff[req_idx];
      sts.release_ok    = in_pool && used_ff[req_idx] && (count_ff < CNT_W'(N));
      sts.ptr_end       = (ptr_ff >= count_ff);
      sts.match         = (qptr_val == req_idx);
      sts.ptr_last_free = ((ptr_ff + CNT_W'(1)) == count_ff);
      sts.used_hit      = used_ff[ptr_idx];
      sts.used_last     = !used_above;
   end

   always_comb begin
      room_sel = '0;
      occ_sel  = '0;
      case (cmd.emit_sel)
         ofra_pkg::SEL_HEAD: begin
            room_sel = ofra_pkg::room_of(fo_ff[0]);
            occ_sel  = occ_ff;
         end
         ofra_pkg::SEL_QPTR: begin
            room_sel = ofra_pkg::room_of(qptr_val);
         end
         ofra_pkg::SEL_REQ_OCC: begin
            room_sel = ofra_pkg::room_of(req_idx);
            occ_sel  = occ_ff;
         end
         ofra_pkg::SEL_REQ: begin
            room_sel = ofra_pkg::room_of(req_idx);
         end
         ofra_pkg::SEL_USED: begin
            room_sel = ofra_pkg::room_of(ptr_idx);
            occ_sel  = occ_tbl_ff[ptr_idx];
         end
         default: begin
            room_sel = '0;
            occ_sel  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_operation;
         num_ff <= req_room_number;
         occ_ff <= req_occupant;
      end
      if (take) begin
         occ_tbl_ff[take_idx] <= occ_ff;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_room_ff   <= room_sel;
         rsp_occ_ff    <= occ_sel;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            fo_ff[i] <= IDX_W'(i);
         end
         count_ff     <= CNT_W'(N);
         used_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fo_ff <= fo_in;
         if (take) begin
            count_ff          <= count_ff - CNT_W'(1);
            used_ff[take_idx] <= 1'b1;
         end else if (cmd.release_room) begin
            count_ff         <= count_ff + CNT_W'(1);
            used_ff[req_idx] <= 1'b0;
         end
         if (cmd.ptr_clr) begin
            ptr_ff <= '0;
         end else if (cmd.ptr_inc) begin
            ptr_ff <= ptr_ff + CNT_W'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_room_out     = rsp_room_ff;
   assign rsp_occupant_out = rsp_occ_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== rtl/ordered_free_list_room_allocator_core.sv =====
// ----------------------------------------------------------------------------
// ordered_free_list_room_allocator_core
// Room pool allocator with an ordered free queue, in-use marks and occupant
// ids; allocate, allocate given room, release and two list operations.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                      Direction
//   req_      operation, room_number, occupant           in,  valid/ready
//   rsp_      status, room_out, occupant_out, last       out, valid/ready
//
// A request is taken only while the sequencer is idle; it is latched on
// acceptance and decoded in the dispatch state, which registers the result
// word of allocate and release. Allocate given room then searches the free
// queue position by position; the list operations emit one word per cycle
// while the result register is free, and the used list also steps past each
// free room it passes. A held result word stalls the sequencer but a new
// request is taken while the last word of the previous one waits. Reset reloads the free queue.
//
module ordered_free_list_room_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ofra_pkg::OP_W-1:0]     req_operation,
   input  logic [ofra_pkg::ROOM_W-1:0]   req_room_number,
   input  logic [ofra_pkg::OCC_W-1:0]    req_occupant,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ofra_pkg::ST_W-1:0]     rsp_status,
   output logic [ofra_pkg::ROOM_W-1:0]   rsp_room_out,
   output logic [ofra_pkg::OCC_W-1:0]    rsp_occupant_out,
   output logic                          rsp_last
);

   ofra_pkg::cmd_type cmd;
   ofra_pkg::sts_type sts;

   ofra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ofra_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_room_number  (req_room_number),
      .req_occupant     (req_occupant),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_room_out     (rsp_room_out),
      .rsp_occupant_out (rsp_occupant_out),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered free-list room allocator. A driver
// feeds requests from a queue filled up front, a monitor predicts every
// result word from its own copy of the room pool and checks the words in
// order, with random idle gaps and a long result stall on the way.
// ----------------------------------------------------------------------------
module tb;

   localparam int LIMIT       = 3_000_000;
   localparam int TARGET_REQS = 370;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 2 * (ofra_pkg::NUM_ROOMS + 4);

   // Operation codes that the block must ignore.
   localparam logic [ofra_pkg::OP_W-1:0] OP_RSVD_A = 3'd5;
   localparam logic [ofra_pkg::OP_W-1:0] OP_RSVD_B = 3'd6;
   localparam logic [ofra_pkg::OP_W-1:0] OP_RSVD_C = 3'd7;

   typedef struct packed {
      logic [ofra_pkg::OP_W-1:0]   op;
      logic [ofra_pkg::ROOM_W-1:0] room;
      logic [ofra_pkg::OCC_W-1:0]  occ;
      logic                        wait_idle;
   } req_type;

   typedef struct packed {
      logic [ofra_pkg::ST_W-1:0]   status;
      logic [ofra_pkg::ROOM_W-1:0] room;
      logic [ofra_pkg::OCC_W-1:0]  occ;
      logic                        last;
   } rsp_type;

   typedef struct packed {
      logic [ofra_pkg::NUM_ROOMS-1:0][ofra_pkg::IDX_W-1:0] order;
      logic [ofra_pkg::CNT_W-1:0]                          count;
      logic [ofra_pkg::NUM_ROOMS-1:0]                      used;
      logic [ofra_pkg::NUM_ROOMS-1:0][ofra_pkg::OCC_W-1:0] occ;
   } pool_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ofra_pkg::ST_W-1:0]   rsp_status;
   logic [ofra_pkg::ROOM_W-1:0] rsp_room_out;
   logic [ofra_pkg::OCC_W-1:0]  rsp_occupant_out;
   logic                        rsp_last;
   req_type drive_req = '0;

   req_type  pending_reqs[$];
   rsp_type  expected_words[$];
   pool_type live_pool;
   pool_type plan_pool;

   logic req_taken = 1'b0;
   logic pause_next = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;
   int   send_gap = 0;
   int   sink_gap = 0;
   int   cycle_cnt = 0;
   int   err_cnt = 0;
   int   planned_reqs = 0;
   int   accepted_reqs = 0;
   int   words_checked = 0;
   int   n_alloc = 0;
   int   n_release = 0;
   int   n_list = 0;
   int   n_ignored = 0;
   int   n_exhausted = 0;

   logic [ofra_pkg::OP_W-1:0]   req_operation_w;
   logic [ofra_pkg::ROOM_W-1:0] req_room_w;
   logic [ofra_pkg::OCC_W-1:0]  req_occ_w;

   assign req_operation_w = drive_req.op;
   assign req_room_w      = drive_req.room;
   assign req_occ_w       = drive_req.occ;

   ordered_free_list_room_allocator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation_w),
      .req_room_number  (req_room_w),
      .req_occupant     (req_occ_w),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_room_out     (rsp_room_out),
      .rsp_occupant_out (rsp_occupant_out),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   // ---------------------------------------------------------------- pool model

   function automatic pool_type fresh_pool();
      pool_type p;
      p = '0;
      for (int i = 0; i < ofra_pkg::NUM_ROOMS; i++) p.order[i] = ofra_pkg::IDX_W'(i);
      p.count = ofra_pkg::CNT_W'(ofra_pkg::NUM_ROOMS);
      return p;
   endfunction

   function automatic logic [ofra_pkg::ROOM_W-1:0] room_label(input int idx);
      return ofra_pkg::ROOM_W'(ofra_pkg::FIRST_ROOM + idx);
   endfunction

   function automatic int slot_of(input logic [ofra_pkg::ROOM_W-1:0] number);
      int n;
      n = int'(number);
      if (n < ofra_pkg::FIRST_ROOM || n >= ofra_pkg::FIRST_ROOM + ofra_pkg::NUM_ROOMS)
         return -1;
      return n - ofra_pkg::FIRST_ROOM;
   endfunction

   function automatic rsp_type make_word(input logic [ofra_pkg::ST_W-1:0]   st,
                                         input logic [ofra_pkg::ROOM_W-1:0] room,
                                         input logic [ofra_pkg::OCC_W-1:0]  occ,
                                         input logic                        fin);
      rsp_type w;
      w.status = st;
      w.room   = room;
      w.occ    = occ;
      w.last   = fin;
      return w;
   endfunction

   // Takes the queue entry at pos out and closes the hole behind it.
   task automatic drop_entry(ref pool_type p, input int pos);
      for (int i = pos; i + 1 < int'(p.count); i++) p.order[i] = p.order[i + 1];
      p.count = p.count - 1'b1;
   endtask

   task automatic apply_request(ref pool_type p, input req_type r, ref rsp_type q[$]);
      int slot;
      int hit;
      int top;
      slot = slot_of(r.room);
      hit  = -1;
      top  = -1;
      case (r.op)
         ofra_pkg::OP_ALLOC: begin
            if (p.count == 0) begin
               q.push_back(make_word(ofra_pkg::ST_NO_FREE, '0, '0, 1'b1));
            end else begin
               slot = int'(p.order[0]);
               drop_entry(p, 0);
               p.used[slot] = 1'b1;
               p.occ[slot]  = r.occ;
               q.push_back(make_word(ofra_pkg::ST_DONE, room_label(slot), r.occ, 1'b1));
            end
         end
         ofra_pkg::OP_ALLOC_GIVEN: begin
            if (slot >= 0 && !p.used[slot]) begin
               for (int i = 0; i < int'(p.count); i++)
                  if (hit < 0 && int'(p.order[i]) == slot) hit = i;
            end
            if (hit < 0) begin
               q.push_back(make_word(ofra_pkg::ST_NOT_FREE, '0, '0, 1'b1));
            end else begin
               drop_entry(p, hit);
               p.used[slot] = 1'b1;
               p.occ[slot]  = r.occ;
               q.push_back(make_word(ofra_pkg::ST_DONE, room_label(slot), r.occ, 1'b1));
            end
         end
         ofra_pkg::OP_RELEASE: begin
            if (slot < 0 || !p.used[slot] || p.count >= ofra_pkg::NUM_ROOMS) begin
               q.push_back(make_word(ofra_pkg::ST_NOT_USED, '0, '0, 1'b1));
            end else begin
               p.used[slot]      = 1'b0;
               p.order[p.count]  = ofra_pkg::IDX_W'(slot);
               p.count           = p.count + 1'b1;
               q.push_back(make_word(ofra_pkg::ST_DONE, room_label(slot), '0, 1'b1));
            end
         end
         ofra_pkg::OP_LIST_FREE: begin
            if (p.count == 0) begin
               q.push_back(make_word(ofra_pkg::ST_EMPTY, '0, '0, 1'b1));
            end else begin
               for (int i = 0; i < int'(p.count); i++)
                  q.push_back(make_word(ofra_pkg::ST_ENTRY, room_label(int'(p.order[i])),
                                        '0, i + 1 == int'(p.count)));
            end
         end
         ofra_pkg::OP_LIST_USED: begin
            if (p.used == '0) begin
               q.push_back(make_word(ofra_pkg::ST_EMPTY, '0, '0, 1'b1));
            end else begin
               for (int i = 0; i < ofra_pkg::NUM_ROOMS; i++) if (p.used[i]) top = i;
               for (int i = 0; i < ofra_pkg::NUM_ROOMS; i++)
                  if (p.used[i])
                     q.push_back(make_word(ofra_pkg::ST_ENTRY, room_label(i), p.occ[i],
                                           i == top));
            end
         end
         default: begin
            // Reserved codes leave the pool alone and produce no word.
         end
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 10);
      return $urandom_range(25, 80);
   endfunction

   function automatic int pick_used(input pool_type p);
      int n;
      int k;
      n = 0;
      for (int i = 0; i < ofra_pkg::NUM_ROOMS; i++) if (p.used[i]) n++;
      if (n == 0) return -1;
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < ofra_pkg::NUM_ROOMS; i++) begin
         if (p.used[i]) begin
            if (k == 0) return i;
            k--;
         end
      end
      return -1;
   endfunction

   // Queues one request and runs it on the planning copy of the pool, so
   // that later choices of rooms follow the state the block will be in.
   task automatic add_item(input logic [ofra_pkg::OP_W-1:0] op, input int room,
                           input int occ);
      req_type r;
      rsp_type scratch[$];
      r.op        = op;
      r.room      = room[ofra_pkg::ROOM_W-1:0];
      r.occ       = occ[ofra_pkg::OCC_W-1:0];
      r.wait_idle = pause_next;
      pause_next  = 1'b0;
      pending_reqs.push_back(r);
      apply_request(plan_pool, r, scratch);
      if (op <= ofra_pkg::OP_LIST_USED) planned_reqs++;
   endtask

   task automatic add_given_free();
      if (plan_pool.count != 0)
         add_item(ofra_pkg::OP_ALLOC_GIVEN,
                  int'(room_label(int'(plan_pool.order[$urandom_range(0,
                                                          plan_pool.count - 1)]))),
                  $urandom_range(0, 65535));
      else
         add_item(ofra_pkg::OP_ALLOC_GIVEN,
                  $urandom_range(ofra_pkg::FIRST_ROOM,
                                 ofra_pkg::FIRST_ROOM + ofra_pkg::NUM_ROOMS - 1),
                  $urandom_range(0, 65535));
   endtask

   task automatic add_release_used();
      int u;
      u = pick_used(plan_pool);
      if (u >= 0) add_item(ofra_pkg::OP_RELEASE, int'(room_label(u)), $urandom_range(0, 65535));
      else add_item(ofra_pkg::OP_RELEASE, $urandom_range(0, 255), $urandom_range(0, 65535));
   endtask

   task automatic build_stimulus();
      int u;
      int n;
      plan_pool = fresh_pool();

      // Directed part: empty and full lists, every error status but no free room,
      // reserved codes and the field extremes.
      add_item(ofra_pkg::OP_LIST_FREE, 0, 0);
      add_item(ofra_pkg::OP_LIST_USED, 255, 65535);
      add_item(ofra_pkg::OP_RELEASE, ofra_pkg::FIRST_ROOM, 0);
      add_item(ofra_pkg::OP_RELEASE, 0, 0);
      add_item(ofra_pkg::OP_RELEASE, 255, 65535);
      add_item(OP_RSVD_A, ofra_pkg::FIRST_ROOM, 1);
      add_item(OP_RSVD_B, 255, 65535);
      add_item(OP_RSVD_C, 0, 0);
      add_item(ofra_pkg::OP_ALLOC, 0, 0);
      add_item(ofra_pkg::OP_ALLOC, 255, 65535);
      add_item(ofra_pkg::OP_ALLOC_GIVEN, ofra_pkg::FIRST_ROOM + ofra_pkg::NUM_ROOMS - 1,
               16'h5a5a);
      add_item(ofra_pkg::OP_ALLOC_GIVEN, ofra_pkg::FIRST_ROOM + ofra_pkg::NUM_ROOMS - 1,
               16'ha5a5);
      add_item(ofra_pkg::OP_ALLOC_GIVEN, ofra_pkg::FIRST_ROOM - 1, 7);
      add_item(ofra_pkg::OP_ALLOC_GIVEN, ofra_pkg::FIRST_ROOM + ofra_pkg::NUM_ROOMS, 7);
      add_item(ofra_pkg::OP_ALLOC_GIVEN, 0, 0);
      add_item(ofra_pkg::OP_ALLOC_GIVEN, 255, 65535);
      add_item(ofra_pkg::OP_ALLOC_GIVEN, ofra_pkg::FIRST_ROOM + ofra_pkg::NUM_ROOMS / 2,
               16'h1234);
      add_item(ofra_pkg::OP_LIST_USED, 0, 0);
      add_item(ofra_pkg::OP_LIST_FREE, 0, 0);
      add_item(ofra_pkg::OP_RELEASE, ofra_pkg::FIRST_ROOM + 1, 65535);
      add_item(ofra_pkg::OP_RELEASE, ofra_pkg::FIRST_ROOM + 1, 0);
      add_item(ofra_pkg::OP_RELEASE, ofra_pkg::FIRST_ROOM + ofra_pkg::NUM_ROOMS, 0);
      add_item(ofra_pkg::OP_LIST_FREE, 255, 0);
      pause_next = 1'b1;

      while (planned_reqs < TARGET_REQS) begin
         if ($urandom_range(0, 7) == 0) pause_next = 1'b1;
         case ($urandom_range(0, 9)) inside
            0, 1, 2: begin
               // Run the pool dry and a little past empty.
               n = int'(plan_pool.count) + $urandom_range(0, 2);
               repeat (n)
                  add_item(ofra_pkg::OP_ALLOC, $urandom_range(0, 255),
                           $urandom_range(0, 65535));
               add_item(ofra_pkg::OP_LIST_USED, 0, 0);
               add_item(ofra_pkg::OP_LIST_FREE, 0, 0);
            end
            3, 4: begin
               // Hand rooms back in random order, now and then twice.
               u = pick_used(plan_pool);
               while (u >= 0) begin
                  add_item(ofra_pkg::OP_RELEASE, int'(room_label(u)),
                           $urandom_range(0, 65535));
                  if ($urandom_range(0, 4) == 0)
                     add_item(ofra_pkg::OP_RELEASE, int'(room_label(u)),
                              $urandom_range(0, 65535));
                  u = pick_used(plan_pool);
               end
               add_item(ofra_pkg::OP_LIST_FREE, 0, 0);
            end
            5, 6: begin
               repeat ($urandom_range(2, 6)) begin
                  if ($urandom_range(0, 3) != 0) add_given_free();
                  else add_item(ofra_pkg::OP_ALLOC_GIVEN, $urandom_range(0, 255),
                                $urandom_range(0, 65535));
               end
               add_item(ofra_pkg::OP_LIST_FREE, 0, 0);
            end
            7, 8: begin
               repeat (6) begin
                  case ($urandom_range(0, 4))
                     0: add_item(ofra_pkg::OP_ALLOC, $urandom_range(0, 255),
                                 $urandom_range(0, 65535));
                     1: add_given_free();
                     2: add_release_used();
                     3: add_item(ofra_pkg::OP_LIST_FREE, $urandom_range(0, 255),
                                 $urandom_range(0, 65535));
                     default: add_item(ofra_pkg::OP_LIST_USED, $urandom_range(0, 255),
                                       $urandom_range(0, 65535));
                  endcase
               end
            end
            default: begin
               repeat (5)
                  add_item(ofra_pkg::OP_W'($urandom_range(0, 7)), $urandom_range(0, 255),
                           $urandom_range(0, 65535));
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : request_driver
      req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Hold the word until it is taken.
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].wait_idle && expected_words.size() != 0 &&
                     hold_left == 0)) begin
         nxt = pending_reqs.pop_front();
         drive_req <= nxt;
         req_valid <= 1'b1;
         if (accepted_reqs >= 200 && accepted_reqs < 260) send_gap <= 0;
         else send_gap <= ($urandom_range(0, 2) == 0) ? idle_len() : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_reqs >= 100) begin
         // One long stall so the block backs up and refuses requests.
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (sink_gap > 0) begin
         rsp_ready <= 1'b0;
         sink_gap  <= sink_gap - 1;
      end else if ((accepted_reqs >= 200 && accepted_reqs < 260) ||
                   $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         sink_gap  <= idle_len() - 1;
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic report_word(input string what, input rsp_type want, input rsp_type got);
      err_cnt++;
      if (err_cnt <= 10) begin
         $display("%0t %s: expected status %0d room %0d occupant %0d last %0b",
                  $realtime, what, want.status, want.room, want.occ, want.last);
         $display("   got status %0d room %0d occupant %0d last %0b",
                  got.status, got.room, got.occ, got.last);
      end
   endtask

   always @(posedge clock) begin : result_monitor
      rsp_type got;
      rsp_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         got = make_word(rsp_status, rsp_room_out, rsp_occupant_out, rsp_last);
         if (expected_words.size() == 0) begin
            report_word("unexpected word", '0, got);
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (got.status !== want.status || got.room !== want.room ||
                got.occ !== want.occ || got.last !== want.last)
               report_word("mismatch", want, got);
         end
      end
      if (!reset && req_valid && req_ready) begin
         accepted_reqs++;
         case (drive_req.op) inside
            ofra_pkg::OP_ALLOC, ofra_pkg::OP_ALLOC_GIVEN: n_alloc++;
            ofra_pkg::OP_RELEASE: n_release++;
            ofra_pkg::OP_LIST_FREE, ofra_pkg::OP_LIST_USED: n_list++;
            default: n_ignored++;
         endcase
         if (drive_req.op == ofra_pkg::OP_ALLOC && live_pool.count == 0) n_exhausted++;
         apply_request(live_pool, drive_req, expected_words);
      end
   end

   // ---------------------------------------------------------------- control

   initial begin
      while (cycle_cnt < LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      live_pool = fresh_pool();
      build_stimulus();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         err_cnt++;
         $display("%0d expected words never arrived", expected_words.size());
      end
      $display("Sent %0d requests: %0d allocations, %0d releases, %0d lists, %0d reserved.",
               accepted_reqs, n_alloc, n_release, n_list, n_ignored);
      $display("Checked %0d result words; an empty pool was asked for a room %0d times.",
               words_checked, n_exhausted);
      if (err_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d errors", err_cnt);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ofra_pkg.sv
rtl/ofra_ctrl.sv
rtl/ofra_dp.sv
rtl/ordered_free_list_room_allocator_core.sv
bench/tb.sv
